FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/i2c_ras_pkg.sv
// Package of the I2C register access sequencer: request and result types,
// bus command, outcome and status codes, and the sequencing phase type.
package i2c_ras_pkg;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_EVENT = 2'd2,
        FUNC_RSVD  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_START = 2'd1,
        CMD_XFER  = 2'd2,
        CMD_STOP  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        OUT_PENDING = 2'd0,
        OUT_OK      = 2'd1,
        OUT_FAIL    = 2'd2,
        OUT_RSVD    = 2'd3
    } t_outcome;

    // Bus status codes with the low three bits cleared.
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_REP_START  = 8'h10;
    localparam logic [7:0] ST_MT_SLA_ACK = 8'h18;
    localparam logic [7:0] ST_MT_SLA_NAK = 8'h20;
    localparam logic [7:0] ST_MT_DAT_ACK = 8'h28;
    localparam logic [7:0] ST_ARB_LOST   = 8'h38;
    localparam logic [7:0] ST_MR_SLA_ACK = 8'h40;
    localparam logic [7:0] ST_MR_SLA_NAK = 8'h48;
    localparam logic [7:0] ST_MR_DAT_NAK = 8'h58;
    localparam logic [7:0] STATUS_MASK   = 8'hF8;

    localparam logic [7:0] RETRY_LIMIT_RESET = 8'd20;
    localparam logic [7:0] RETRY_COUNT_MAX   = 8'hFF;

    typedef enum logic [7:0] {
        PH_IDLE    = 8'b0000_0001,
        PH_START   = 8'b0000_0010,
        PH_SLAW    = 8'b0000_0100,
        PH_REG     = 8'b0000_1000,
        PH_DATA    = 8'b0001_0000,
        PH_RESTART = 8'b0010_0000,
        PH_SLAR    = 8'b0100_0000,
        PH_RX      = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic [1:0] func;
        logic [3:0] dev_id;
        logic [2:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] bus_status;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] bus_cmd;
        logic [7:0] tx_byte;
        logic       done_res;
        logic [1:0] outcome;
        logic [7:0] read_data;
    } t_out_item;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] retry_count;
        logic       is_read;
        logic [7:0] held_reg;
        logic [7:0] held_data;
        logic [6:0] held_device;
        logic [7:0] read_byte;
    } t_seq_state;

endpackage

FILE: rtl/i2c_ras_step.sv
// Next-state and result logic of the I2C register access sequencer.
// Purely combinational; depends on i2c_ras_pkg.
module i2c_ras_step
    import i2c_ras_pkg::*;
(
    input  t_seq_state  i_state,
    input  t_in_item    i_item,
    input  logic [7:0]  i_retry_limit,
    output t_seq_state  o_state,
    output t_out_item   o_result
);

    logic [7:0] status;
    logic [7:0] cnt_inc;
    logic       begin_req;
    logic       event_req;

    assign status    = i_item.bus_status & STATUS_MASK;
    assign cnt_inc   = (i_state.retry_count < RETRY_COUNT_MAX) ?
                       i_state.retry_count + 8'd1 : i_state.retry_count;
    assign begin_req = (i_item.func == FUNC_WRITE) || (i_item.func == FUNC_READ);
    assign event_req = (i_item.func == FUNC_EVENT);

    always_comb begin
        t_seq_state nxt;
        t_out_item  res;
        logic       do_finish;
        logic       do_retry;
        t_outcome   fin_code;

        nxt       = i_state;
        res       = '0;
        do_finish = 1'b0;
        do_retry  = 1'b0;
        fin_code  = OUT_FAIL;
        res.bus_cmd = CMD_NONE;

        if (begin_req && (i_state.phase == PH_IDLE)) begin
            nxt.held_device = {i_item.dev_id, i_item.dev_addr};
            nxt.held_reg    = i_item.reg_addr;
            nxt.held_data   = i_item.write_data;
            nxt.is_read     = (i_item.func == FUNC_READ);
            nxt.retry_count = '0;
            if (i_retry_limit == '0) begin
                do_finish = 1'b1;
            end else begin
                res.bus_cmd = CMD_START;
                nxt.phase   = PH_START;
            end
        end else if (event_req && (i_state.phase != PH_IDLE)) begin
            unique case (i_state.phase)
                PH_START, PH_RESTART: begin
                    if (status == ST_ARB_LOST) begin
                        do_retry = 1'b1;
                    end else if (status != ST_START && status != ST_REP_START) begin
                        do_finish = 1'b1;
                    end else if (i_state.phase == PH_START) begin
                        res.bus_cmd = CMD_XFER;
                        res.tx_byte = {i_state.held_device, 1'b0};
                        nxt.phase   = PH_SLAW;
                    end else begin
                        res.bus_cmd = CMD_XFER;
                        res.tx_byte = {i_state.held_device, 1'b1};
                        nxt.phase   = PH_SLAR;
                    end
                end
                PH_SLAW: begin
                    if (status == ST_MT_SLA_NAK || status == ST_ARB_LOST) begin
                        do_retry = 1'b1;
                    end else if (status == ST_MT_SLA_ACK) begin
                        res.bus_cmd = CMD_XFER;
                        res.tx_byte = i_state.held_reg;
                        nxt.phase   = PH_REG;
                    end else begin
                        do_finish = 1'b1;
                    end
                end
                PH_REG: begin
                    if (status != ST_MT_DAT_ACK) begin
                        do_finish = 1'b1;
                    end else if (i_state.is_read) begin
                        res.bus_cmd = CMD_START;
                        nxt.phase   = PH_RESTART;
                    end else begin
                        res.bus_cmd = CMD_XFER;
                        res.tx_byte = i_state.held_data;
                        nxt.phase   = PH_DATA;
                    end
                end
                PH_DATA: begin
                    do_finish = 1'b1;
                    fin_code  = (status == ST_MT_DAT_ACK) ? OUT_OK : OUT_FAIL;
                end
                PH_SLAR: begin
                    if (status == ST_MR_SLA_NAK || status == ST_ARB_LOST) begin
                        do_retry = 1'b1;
                    end else if (status == ST_MR_SLA_ACK) begin
                        res.bus_cmd = CMD_XFER;
                        nxt.phase   = PH_RX;
                    end else begin
                        do_finish = 1'b1;
                    end
                end
                PH_RX: begin
                    do_finish = 1'b1;
                    if (status == ST_MR_DAT_NAK) begin
                        nxt.read_byte = i_item.rx_byte;
                        fin_code      = OUT_OK;
                    end
                end
                default: begin
                    nxt = i_state;
                end
            endcase
        end

        // A retry restarts the transfer unless the attempt budget is used up.
        if (do_retry) begin
            nxt.retry_count = cnt_inc;
            if (cnt_inc < i_retry_limit) begin
                res.bus_cmd = CMD_START;
                nxt.phase   = PH_START;
            end else begin
                do_finish = 1'b1;
            end
        end

        if (do_finish) begin
            res.bus_cmd  = CMD_STOP;
            res.tx_byte  = '0;
            res.done_res = 1'b1;
            res.outcome  = fin_code;
            nxt.phase    = PH_IDLE;
        end

        res.read_data = nxt.read_byte;
        o_state  = nxt;
        o_result = res;
    end

endmodule

FILE: rtl/i2c_register_access_sequencer_unit.sv
// Top level of the I2C register access sequencer: state registers, result
// register and configuration register. Depends on i2c_ras_pkg and i2c_ras_step.
//
// Usage. Requests arrive on the input channel (i_in_valid, o_in_stall, i_in).
// A request is a begin write, a begin read, or a status event from the byte
// engine. Every accepted request yields exactly one result on the output
// channel (o_out_valid, i_out_stall, o_out): the next bus command, the byte
// to transmit, and on the final stop the done flag, the outcome and the byte
// that was read.
// The result of an accepted request is registered and presented from the
// next cycle on. Throughput is one request per cycle unless a waiting result
// is stalled; the only path between the two registers is the short step logic
// of the phase sequencer. The result register accepts a new request in the
// same cycle that its current result is taken, so the block stalls its input
// only while a result waits and the receiver stalls too.
// The retry limit is written through its own valid/ready port, which is
// always ready; write it only while no transaction is in flight.
// Synchronous reset returns the sequencer to idle, clears the retry count, the
// read flag and the read byte, sets the retry limit to 20 and empties the
// result register.
module i2c_register_access_sequencer_unit
    import i2c_ras_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    t_phase     r_phase;
    logic [7:0] r_retry_count;
    logic       r_is_read;
    logic [7:0] r_held_reg;
    logic [7:0] r_held_data;
    logic [6:0] r_held_device;
    logic [7:0] r_read_byte;
    logic [7:0] r_retry_limit;
    logic       r_out_valid;
    t_out_item  r_out;

    t_seq_state cur_state;
    t_seq_state n_state;
    t_out_item  n_out;
    logic       in_accept;

    // The input is held off only when a waiting result cannot leave.
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign cur_state = '{
        phase:       r_phase,
        retry_count: r_retry_count,
        is_read:     r_is_read,
        held_reg:    r_held_reg,
        held_data:   r_held_data,
        held_device: r_held_device,
        read_byte:   r_read_byte
    };

    i2c_ras_step u_step (
        .i_state       (cur_state),
        .i_item        (i_in),
        .i_retry_limit (r_retry_limit),
        .o_state       (n_state),
        .o_result      (n_out)
    );

    // Control state and the reset-valued registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_retry_count <= '0;
            r_is_read     <= 1'b0;
            r_read_byte   <= '0;
            r_retry_limit <= RETRY_LIMIT_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_retry_limit <= i_cfg_data;
            end
            if (in_accept) begin
                r_phase       <= n_state.phase;
                r_retry_count <= n_state.retry_count;
                r_is_read     <= n_state.is_read;
                r_read_byte   <= n_state.read_byte;
                r_out_valid   <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    // Transaction operands and the result payload need no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_held_reg    <= n_state.held_reg;
            r_held_data   <= n_state.held_data;
            r_held_device <= n_state.held_device;
            r_out         <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: rtl/i2c_ras_checker.sv
// Port-level checker for the I2C register access sequencer, bound to the top.
// Depends on i2c_ras_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2c_ras_checker
    import i2c_ras_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out
);

    logic       in_acc;
    logic       out_acc;
    logic       out_held;
    logic       rd_step;
    logic       stop_final;
    logic       out_pending;
    logic       done_ok;
    logic [7:0] rd_byte;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = o_out_valid && !i_out_stall;
    assign out_held    = o_out_valid && i_out_stall;
    assign rd_step     = out_acc && in_acc;
    assign stop_final  = (o_out.bus_cmd == CMD_STOP) &&
                         (o_out.outcome == OUT_OK || o_out.outcome == OUT_FAIL);
    assign out_pending = (o_out.outcome == OUT_PENDING);
    assign done_ok     = o_out.done_res && (o_out.outcome == OUT_OK);
    assign rd_byte     = o_out.read_data;

    // A stalled result stays in place.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(o_out))
    // Every accepted request shows a result in the next cycle.
    `ASSERT_NEXT(a_req_result, i_clk, i_rst_n, in_acc, o_out_valid)
    // A finished transaction always ends with a stop and a final outcome.
    `ASSERT_IMPLY(a_done_stop, i_clk, i_rst_n, o_out_valid && o_out.done_res, stop_final)
    // Without done the outcome stays pending.
    `ASSERT_IMPLY(a_pending, i_clk, i_rst_n, o_out_valid && !o_out.done_res, out_pending)
    // The read byte changes only with a successful finish.
    `ASSERT_NEXT(a_rd_stable, i_clk, i_rst_n, rd_step, rd_byte == $past(rd_byte) || done_ok)

endmodule

bind i2c_register_access_sequencer_unit i2c_ras_checker u_i2c_ras_checker (.*);
